// ----- rtl/iee_pkg.sv -----
// Shared package for the infix expression evaluator.
// Holds widths, ASCII codes, request types, command/status structs.
// No dependencies.
package iee_pkg;

    localparam int VALUE_BITS = 32;                 // signed width of a result
    localparam int MAG_W      = VALUE_BITS;         // magnitudes up to 2^(VALUE_BITS-1)
    localparam int SUM_W      = 64;                 // running sum width
    localparam int OUT_W      = 32;                 // value field width
    localparam int CNT_W      = $clog2(MAG_W + 1);  // iteration counter

    localparam logic [MAG_W-1:0] MAX_MAG = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] VALUE_MASK = (SUM_W'(1) << VALUE_BITS) - SUM_W'(1);
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam int         DEC_BASE = 10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic        [1:0]       status;
    } out_item_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_MUL  = 2'd1,
        PEND_DIV  = 2'd2
    } pend_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_OVF  = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_SPACE,
        CLS_ADDSUB,
        CLS_MULDIV,
        CLS_OTHER
    } cls_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,        // latch accepted request
        OP_DIGIT,       // shift a digit into the accumulator
        OP_CLOSE_LOAD,  // close number, no pending op: fold term, start new one
        OP_MD_START,    // close number into a pending * or /
        OP_MD_DIV0,     // close number, divide by zero
        OP_MD_FINISH,   // write multiply/divide result back to the term
        OP_POST,        // operator side effects after the close
        OP_FOLD,        // fold the term into the sum
        OP_EMIT         // load result register, clear expression state
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        cls_t  cls;
        logic  last;
        logic  number_open;
        pend_t pend;
        logic  acc_zero;
        logic  md_done;
    } dp_stat_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        if (c inside {[CH_ZERO:CH_NINE]}) r = CLS_DIGIT;
        else if (c == CH_SPACE) r = CLS_SPACE;
        else if (c inside {CH_PLUS, CH_MINUS}) r = CLS_ADDSUB;
        else if (c inside {CH_STAR, CH_SLASH}) r = CLS_MULDIV;
        else r = CLS_OTHER;
        return r;
    endfunction

endpackage

// ----- rtl/iee_muldiv.sv -----
// Iterative unsigned multiply (shift-add) and divide (restoring), one bit a cycle.
// Depends on iee_pkg.
module iee_muldiv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         is_div,
    input  logic [iee_pkg::MAG_W-1:0]    lhs,
    input  logic [iee_pkg::MAG_W-1:0]    rhs,
    output logic [2*iee_pkg::MAG_W-1:0]  product,
    output logic [iee_pkg::MAG_W-1:0]    quotient,
    output logic                         done
);
    import iee_pkg::*;

    logic [MAG_W-1:0] hi_reg, hi_next;
    logic [MAG_W-1:0] lo_reg, lo_next;
    logic [MAG_W-1:0] rhs_reg, rhs_next;
    logic             div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [MAG_W:0] add_sum;
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           fits;

    assign add_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, rhs_reg} : '0);
    assign trial   = {hi_reg, lo_reg[MAG_W-1]};
    assign fits    = trial >= {1'b0, rhs_reg};
    assign diff    = trial - {1'b0, rhs_reg};

    always_comb begin
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        rhs_next = rhs_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (start) begin
            hi_next  = '0;
            lo_next  = lhs;
            rhs_next = rhs;
            div_next = is_div;
            cnt_next = CNT_W'(MAG_W);
        end else if (cnt_reg != '0) begin
            if (div_reg) begin
                hi_next = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                lo_next = {lo_reg[MAG_W-2:0], fits};
            end else begin
                hi_next = add_sum[MAG_W:1];
                lo_next = {add_sum[0], lo_reg[MAG_W-1:1]};
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        rhs_reg <= rhs_next;
        div_reg <= div_next;
    end

    assign product  = {hi_reg, lo_reg};
    assign quotient = lo_reg;
    assign done     = (cnt_reg == '0);

endmodule

// ----- rtl/iee_datapath.sv -----
// Datapath: expression state (sum, term, accumulator), fold logic, result register.
// Depends on iee_pkg and iee_muldiv.
module iee_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  iee_pkg::in_item_t   s_request,
    input  iee_pkg::dp_cmd_t    cmd,
    output iee_pkg::dp_stat_t   stat,
    output iee_pkg::out_item_t  m_request
);
    import iee_pkg::*;

    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0] term_reg, term_next;
    logic             neg_reg, neg_next;
    logic             started_reg, started_next;
    logic [MAG_W-1:0] acc_reg, acc_next;
    logic             open_reg, open_next;
    pend_t            pend_reg, pend_next;
    err_t             err_reg, err_next;
    out_item_t        out_reg, out_next;

    // fold of the current term into the running sum, saturating
    logic [SUM_W-1:0] term_ext, fold_v, fold_add, fold_sum;
    logic             fold_ovf;

    assign term_ext = {{(SUM_W-MAG_W){1'b0}}, term_reg};
    assign fold_v   = neg_reg ? (~term_ext + SUM_W'(1)) : term_ext;
    assign fold_add = sum_reg + fold_v;
    assign fold_ovf = (sum_reg[SUM_W-1] == fold_v[SUM_W-1]) &&
                      (fold_add[SUM_W-1] != sum_reg[SUM_W-1]);
    assign fold_sum = fold_ovf ? (fold_v[SUM_W-1] ? SUM_MIN : SUM_MAX) : fold_add;

    // digit shift-in: acc*10 + d
    logic [3:0]       digit;
    logic [MAG_W+3:0] acc10;

    assign digit = 4'(char_reg - CH_ZERO);
    assign acc10 = {acc_reg, 3'b000} + {1'b0, acc_reg, 1'b0} + {{MAG_W{1'b0}}, digit};

    // final range check: upper bits must be pure sign extension
    logic [SUM_W-VALUE_BITS:0] sum_top;
    logic                      in_range;
    logic [SUM_W-1:0]          sum_masked;

    assign sum_top    = sum_reg[SUM_W-1:VALUE_BITS-1];
    assign in_range   = (&sum_top) || (~|sum_top);
    assign sum_masked = sum_reg & VALUE_MASK;

    logic                 md_start, md_done;
    logic [2*MAG_W-1:0]   md_product;
    logic [MAG_W-1:0]     md_quotient;

    assign md_start = (cmd.op == OP_MD_START);

    iee_muldiv u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (md_start),
        .is_div   (pend_reg == PEND_DIV),
        .lhs      (started_reg ? term_reg : '0),
        .rhs      (acc_reg),
        .product  (md_product),
        .quotient (md_quotient),
        .done     (md_done)
    );

    always_comb begin
        char_next    = char_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        term_next    = term_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        acc_next     = acc_reg;
        open_next    = open_reg;
        pend_next    = pend_reg;
        err_next     = err_reg;
        out_next     = out_reg;

        case (cmd.op)
            OP_LOAD: begin
                char_next = s_request.char_code;
                last_next = s_request.last_char;
            end
            OP_DIGIT: begin
                if (acc10 > {4'b0000, MAX_MAG}) begin
                    acc_next = MAX_MAG;
                    if (err_reg == ERR_NONE) err_next = ERR_OVF;
                end else begin
                    acc_next = acc10[MAG_W-1:0];
                end
                open_next = 1'b1;
            end
            OP_CLOSE_LOAD: begin
                if (started_reg) begin
                    sum_next = fold_sum;
                    neg_next = 1'b0;
                    if (fold_ovf && err_reg == ERR_NONE) err_next = ERR_OVF;
                end
                term_next    = acc_reg;
                started_next = 1'b1;
                acc_next     = '0;
                open_next    = 1'b0;
                pend_next    = PEND_NONE;
            end
            OP_MD_DIV0: begin
                if (err_reg == ERR_NONE) err_next = ERR_DIV0;
                term_next    = '0;
                started_next = 1'b1;
                acc_next     = '0;
                open_next    = 1'b0;
                pend_next    = PEND_NONE;
            end
            OP_MD_FINISH: begin
                if (pend_reg == PEND_DIV) begin
                    term_next = md_quotient;
                end else if (md_product > {{MAG_W{1'b0}}, MAX_MAG}) begin
                    term_next = MAX_MAG;
                    if (err_reg == ERR_NONE) err_next = ERR_OVF;
                end else begin
                    term_next = md_product[MAG_W-1:0];
                end
                started_next = 1'b1;
                acc_next     = '0;
                open_next    = 1'b0;
                pend_next    = PEND_NONE;
            end
            OP_POST: begin
                if (classify(char_reg) == CLS_ADDSUB) begin
                    if (started_reg) begin
                        sum_next     = fold_sum;
                        term_next    = '0;
                        started_next = 1'b0;
                        if (fold_ovf && err_reg == ERR_NONE) err_next = ERR_OVF;
                    end
                    neg_next  = (char_reg == CH_MINUS);
                    pend_next = PEND_NONE;
                end else if (classify(char_reg) == CLS_MULDIV) begin
                    pend_next = (char_reg == CH_STAR) ? PEND_MUL : PEND_DIV;
                end
            end
            OP_FOLD: begin
                if (started_reg) begin
                    sum_next     = fold_sum;
                    term_next    = '0;
                    neg_next     = 1'b0;
                    started_next = 1'b0;
                    if (fold_ovf && err_reg == ERR_NONE) err_next = ERR_OVF;
                end
            end
            OP_EMIT: begin
                if (err_reg != ERR_NONE) begin
                    out_next.status = err_reg;
                    out_next.value  = '0;
                end else if (!in_range) begin
                    out_next.status = ERR_OVF;
                    out_next.value  = '0;
                end else begin
                    out_next.status = ERR_NONE;
                    out_next.value  = sum_masked[OUT_W-1:0];
                end
                sum_next     = '0;
                term_next    = '0;
                neg_next     = 1'b0;
                started_next = 1'b0;
                acc_next     = '0;
                open_next    = 1'b0;
                pend_next    = PEND_NONE;
                err_next     = ERR_NONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            term_reg    <= '0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            acc_reg     <= '0;
            open_reg    <= 1'b0;
            pend_reg    <= PEND_NONE;
            err_reg     <= ERR_NONE;
        end else begin
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            acc_reg     <= acc_next;
            open_reg    <= open_next;
            pend_reg    <= pend_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign stat.cls         = classify(char_reg);
    assign stat.last        = last_reg;
    assign stat.number_open = open_reg;
    assign stat.pend        = pend_reg;
    assign stat.acc_zero    = (acc_reg == '0);
    assign stat.md_done     = md_done;

    assign m_request = out_reg;

endmodule

// ----- rtl/iee_ctrl.sv -----
// Controller FSM: sequences character handling, number close, fold and result hand-off.
// Depends on iee_pkg.
module iee_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  iee_pkg::dp_stat_t stat,
    output iee_pkg::dp_cmd_t  cmd
);
    import iee_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_CLOSE    = 7'b0000100,
        S_ITER     = 7'b0001000,
        S_POST     = 7'b0010000,
        S_EMIT     = 7'b0100000,
        S_SPARE    = 7'b1000000   // unused; recovers to idle
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.cls)
                    CLS_DIGIT: begin
                        cmd.op     = OP_DIGIT;
                        state_next = stat.last ? S_CLOSE : S_IDLE;
                    end
                    CLS_OTHER: begin
                        state_next = stat.last ? S_CLOSE : S_IDLE;
                    end
                    default: begin
                        state_next = S_CLOSE;
                    end
                endcase
            end
            S_CLOSE: begin
                if (!stat.number_open) begin
                    state_next = S_POST;
                end else if (stat.pend == PEND_NONE) begin
                    cmd.op     = OP_CLOSE_LOAD;
                    state_next = S_POST;
                end else if (stat.pend == PEND_DIV && stat.acc_zero) begin
                    cmd.op     = OP_MD_DIV0;
                    state_next = S_POST;
                end else begin
                    cmd.op     = OP_MD_START;
                    state_next = S_ITER;
                end
            end
            S_ITER: begin
                if (stat.md_done) begin
                    cmd.op     = OP_MD_FINISH;
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (stat.last) begin
                    cmd.op     = OP_FOLD;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_POST;
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    cmd.op       = OP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/infix_expression_evaluator_core.sv -----
// Infix expression evaluator (+ - * /, precedence, truncating divide), one char per request.
// Per char: a digit or ignored char passes through idle and dispatch; a space or operator
// also through close and post; one closing a * or / term also iterates in the shift-add /
// restoring unit, which retires one bit a cycle. Last char: after the fold, the result
// register loads in the emit state, later only while the previous result waits, and the
// controller returns to idle for the next request. Synchronous active-low reset clears
// all expression state. Depends on iee_pkg, iee_ctrl, iee_datapath, iee_muldiv.
module infix_expression_evaluator_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iee_pkg::in_item_t   s_request,
    output logic                m_valid,
    input  logic                m_ready,
    output iee_pkg::out_item_t  m_request
);
    import iee_pkg::*;

    // Command/status pair between the controller and the datapath.
    // The controller only sequences; every architectural register
    // (running sum, term, sign, pending op, digit accumulator, error)
    // sits in the datapath and changes only on a command.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: takes a request in idle, dispatches on the character
    // class, closes an open number (plain load, divide-by-zero flag, or a
    // multi-cycle multiply/divide), applies the operator, and on the last character
    // folds the term and hands the result to the output register.
    iee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: 64-bit saturating sum, magnitude term with sign,
    // iterative multiply/divide unit, and the result register that
    // decouples the output channel from the input side.
    iee_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_request (s_request),
        .cmd       (cmd),
        .stat      (stat),
        .m_request (m_request)
    );

endmodule
